FILE: rtl/srr_pkg.sv
// ---------------------------------------------------------------------------
// srr_pkg: shared definitions for the square region rotator
// Widths, opcodes, status codes and the grid memory request structure.
// ---------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

   localparam int MAX_SIDE   = 32;
   localparam int SIDE_RESET = 32;

   localparam int VAL_W  = 11;
   localparam int SIDE_W = 6;
   localparam int OP_W   = 2;
   localparam int POS_W  = 6;
   localparam int RAD_W  = 4;
   localparam int OFF_W  = RAD_W + 1;
   localparam int CMP_W  = 8;

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int FILL_LAST_RESET = ((SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET) - 1;

   localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_ROTATE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_CCW = 1'b1;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  wdata;
   } mem_req_type;

endpackage

`default_nettype wire

FILE: rtl/srr_if.sv
// ---------------------------------------------------------------------------
// srr_if: channel interfaces of the square region rotator
// Request, response and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface srr_req_if;
   logic                       valid;
   logic                       ready;
   logic [srr_pkg::OP_W-1:0]   opcode;
   logic [srr_pkg::POS_W-1:0]  row;
   logic [srr_pkg::POS_W-1:0]  col;
   logic [srr_pkg::RAD_W-1:0]  radius;
   logic                       direction;

   modport source (output valid, opcode, row, col, radius, direction, input ready);
   modport sink   (input valid, opcode, row, col, radius, direction, output ready);
endinterface

interface srr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [srr_pkg::VAL_W-1:0]  cell_value;
   logic                       status;

   modport source (output valid, cell_value, status, input ready);
   modport sink   (input valid, cell_value, status, output ready);
endinterface

interface srr_csr_if;
   logic                       valid;
   logic                       ready;
   logic [srr_pkg::SIDE_W-1:0] side;

   modport source (output valid, side, input ready);
   modport sink   (input valid, side, output ready);
endinterface

`default_nettype wire

FILE: rtl/srr_grid_mem.sv
// ---------------------------------------------------------------------------
// srr_grid_mem: grid cell store
// Single address memory with one write or one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_grid_mem (
   input  wire logic                       clock,
   input  wire srr_pkg::mem_req_type       mem_req,
   output logic [srr_pkg::VAL_W-1:0]       rd_data
);

   logic [srr_pkg::VAL_W-1:0] grid_mem [srr_pkg::DEPTH];
   logic [srr_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         grid_mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= grid_mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/square_region_rotator_core.sv
// ---------------------------------------------------------------------------
// square_region_rotator_core: grid store with square region rotation
// Keeps an n-by-n grid and serves initialise, rotate and read requests.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one operation per transaction; rsp_chan returns exactly
//   one response (cell value and status) per request, in order. csr_chan
//   writes the side register and is always ready; write it only while idle.
//   One request is handled at a time and req_chan.ready is low meanwhile.
//   A read passes through the read and wait states to the done state; an
//   initialise refills the n-by-n grid row-major; a rejected request goes
//   straight to the done state. A rotation moves four cells per group over
//   the single memory port: four reads, then four writes.
//   After reset the grid is filled row-major in a pass of one cell per
//   cycle, and no request is accepted until it ends; register writes are
//   taken throughout.
//   The response sits in an output register; while the receiver stalls the
//   block still accepts and works on the next request, and holds that one
//   in its final state until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module square_region_rotator_core (
   input  wire logic   clock,
   input  wire logic   reset,
   srr_req_if.sink     req_chan,
   srr_rsp_if.source   rsp_chan,
   srr_csr_if.sink     csr_chan
);

   localparam logic [2:0] ST_FILL  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_RWAIT = 3'd3;
   localparam logic [2:0] ST_ROT   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [srr_pkg::SIDE_W-1:0]   side_ff, side_in;
   logic [srr_pkg::IDX_W-1:0]    r_ff, r_in, c_ff, c_in;
   logic [srr_pkg::IDX_W-1:0]    fill_last_ff, fill_last_in;
   logic [srr_pkg::VAL_W-1:0]    v_ff, v_in;
   logic                         fill_rsp_ff, fill_rsp_in;
   logic [srr_pkg::RAD_W-1:0]    i_ff, i_in, j_ff, j_in;
   logic [2:0]                   phase_ff, phase_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [srr_pkg::IDX_W-1:0]    base_row_ff, base_row_in, base_col_ff, base_col_in;
   logic [srr_pkg::RAD_W-1:0]    rad_ff, rad_in;
   logic                         dir_ff, dir_in;
   logic [srr_pkg::VAL_W-1:0]    value_ff, value_in;
   logic                         status_ff, status_in;
   logic [srr_pkg::VAL_W-1:0]    rsp_value_ff;
   logic                         rsp_status_ff;
   logic [srr_pkg::VAL_W-1:0]    val_ff [4];

   logic                         req_accept;
   logic                         rsp_load;
   logic [srr_pkg::CMP_W-1:0]    n_eff, row_x, col_x, rad_x;
   logic                         rot_ok, read_ok;
   logic [srr_pkg::OFF_W-1:0]    two_r, ri, rj, orow, ocol;
   logic [srr_pkg::IDX_W-1:0]    row_sel, col_sel;
   logic [1:0]                   cap_idx, src_idx;
   logic                         cap_en;
   srr_pkg::mem_req_type         mem_req;
   logic [srr_pkg::VAL_W-1:0]    rd_data;

   srr_grid_mem u_grid_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign n_eff = (srr_pkg::CMP_W'(side_ff) > srr_pkg::CMP_W'(srr_pkg::MAX_SIDE)) ?
                  srr_pkg::CMP_W'(srr_pkg::MAX_SIDE) : srr_pkg::CMP_W'(side_ff);
   assign row_x = srr_pkg::CMP_W'(req_chan.row);
   assign col_x = srr_pkg::CMP_W'(req_chan.col);
   assign rad_x = srr_pkg::CMP_W'(req_chan.radius);

   assign rot_ok  = (row_x > rad_x) && (col_x > rad_x) &&
                    (row_x + rad_x <= n_eff) && (col_x + rad_x <= n_eff);
   assign read_ok = (row_x != '0) && (col_x != '0) && (row_x <= n_eff) && (col_x <= n_eff);

   // The four cells of one group are the images of offset (i,j) under a quarter turn.
   assign two_r = {rad_ff, 1'b0};
   assign ri    = two_r - srr_pkg::OFF_W'(i_ff);
   assign rj    = two_r - srr_pkg::OFF_W'(j_ff);

   always_comb begin
      case (phase_ff[1:0])
         2'd0: begin
            orow = srr_pkg::OFF_W'(i_ff);
            ocol = srr_pkg::OFF_W'(j_ff);
         end
         2'd1: begin
            orow = srr_pkg::OFF_W'(j_ff);
            ocol = ri;
         end
         2'd2: begin
            orow = ri;
            ocol = rj;
         end
         default: begin
            orow = rj;
            ocol = srr_pkg::OFF_W'(i_ff);
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_FILL) begin
         row_sel = r_ff;
         col_sel = c_ff;
      end else if (state_ff == ST_ROT) begin
         row_sel = srr_pkg::IDX_W'(srr_pkg::CMP_W'(base_row_ff) + srr_pkg::CMP_W'(orow));
         col_sel = srr_pkg::IDX_W'(srr_pkg::CMP_W'(base_col_ff) + srr_pkg::CMP_W'(ocol));
      end else begin
         row_sel = base_row_ff;
         col_sel = base_col_ff;
      end
   end

   // Clockwise each cell takes the value of the previous one in the group.
   assign src_idx = (dir_ff == srr_pkg::DIR_CCW) ? (phase_ff[1:0] + 2'd1) :
                                                  (phase_ff[1:0] - 2'd1);
   assign cap_idx = phase_ff[1:0] - 2'd1;
   assign cap_en  = (state_ff == ST_ROT) && (phase_ff != 3'd0) &&
                    (!phase_ff[2] || (phase_ff[1:0] == 2'd0));

   always_comb begin
      mem_req.addr  = srr_pkg::ADDR_W'(srr_pkg::ADDR_W'(row_sel) *
                                       srr_pkg::ADDR_W'(srr_pkg::MAX_SIDE))
                      + srr_pkg::ADDR_W'(col_sel);
      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.wdata = ((phase_ff == 3'd4) && (src_idx == 2'd3)) ? rd_data : val_ff[src_idx];
      unique case (state_ff)
         ST_FILL: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = v_ff;
         end
         ST_READ: begin
            mem_req.re = 1'b1;
         end
         ST_ROT: begin
            mem_req.we = phase_ff[2];
            mem_req.re = !phase_ff[2];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      fill_last_in = fill_last_ff;
      v_in         = v_ff;
      fill_rsp_in  = fill_rsp_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      phase_in     = phase_ff;
      base_row_in  = base_row_ff;
      base_col_in  = base_col_ff;
      rad_in       = rad_ff;
      dir_in       = dir_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (csr_chan.valid && csr_chan.ready) begin
         side_in = csr_chan.side;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               value_in  = '0;
               status_in = srr_pkg::STATUS_DONE;
               state_in  = ST_DONE;
               unique case (req_chan.opcode)
                  srr_pkg::OP_INIT: begin
                     r_in         = '0;
                     c_in         = '0;
                     v_in         = srr_pkg::VAL_W'(1);
                     fill_last_in = srr_pkg::IDX_W'(n_eff - srr_pkg::CMP_W'(1));
                     fill_rsp_in  = 1'b1;
                     if (n_eff != '0) begin
                        state_in = ST_FILL;
                     end
                  end
                  srr_pkg::OP_ROTATE: begin
                     base_row_in = srr_pkg::IDX_W'(row_x - rad_x - srr_pkg::CMP_W'(1));
                     base_col_in = srr_pkg::IDX_W'(col_x - rad_x - srr_pkg::CMP_W'(1));
                     rad_in      = req_chan.radius;
                     dir_in      = req_chan.direction;
                     i_in        = '0;
                     j_in        = '0;
                     phase_in    = '0;
                     if (!rot_ok) begin
                        status_in = srr_pkg::STATUS_ERROR;
                     end else if (req_chan.radius != '0) begin
                        state_in = ST_ROT;
                     end
                  end
                  srr_pkg::OP_READ: begin
                     base_row_in = srr_pkg::IDX_W'(row_x - srr_pkg::CMP_W'(1));
                     base_col_in = srr_pkg::IDX_W'(col_x - srr_pkg::CMP_W'(1));
                     if (read_ok) begin
                        state_in = ST_READ;
                     end else begin
                        status_in = srr_pkg::STATUS_ERROR;
                     end
                  end
                  default: begin
                     status_in = srr_pkg::STATUS_ERROR;
                  end
               endcase
            end
         end
         ST_FILL: begin
            v_in = v_ff + srr_pkg::VAL_W'(1);
            if (c_ff == fill_last_ff) begin
               c_in = '0;
               if (r_ff == fill_last_ff) begin
                  state_in = fill_rsp_ff ? ST_DONE : ST_IDLE;
               end else begin
                  r_in = r_ff + srr_pkg::IDX_W'(1);
               end
            end else begin
               c_in = c_ff + srr_pkg::IDX_W'(1);
            end
         end
         ST_READ: begin
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            value_in = rd_data;
            state_in = ST_DONE;
         end
         ST_ROT: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd7) begin
               if (j_ff == rad_ff) begin
                  j_in = '0;
                  if (i_ff == rad_ff - srr_pkg::RAD_W'(1)) begin
                     state_in = ST_DONE;
                  end else begin
                     i_in = i_ff + srr_pkg::RAD_W'(1);
                  end
               end else begin
                  j_in = j_ff + srr_pkg::RAD_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         side_ff      <= srr_pkg::SIDE_W'(srr_pkg::SIDE_RESET);
         r_ff         <= '0;
         c_ff         <= '0;
         fill_last_ff <= srr_pkg::IDX_W'(srr_pkg::FILL_LAST_RESET);
         v_ff         <= srr_pkg::VAL_W'(1);
         fill_rsp_ff  <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         fill_last_ff <= fill_last_in;
         v_ff         <= v_in;
         fill_rsp_ff  <= fill_rsp_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_row_ff <= base_row_in;
      base_col_ff <= base_col_in;
      rad_ff      <= rad_in;
      dir_ff      <= dir_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      if (cap_en) begin
         val_ff[cap_idx] <= rd_data;
      end
      if (rsp_load) begin
         rsp_value_ff  <= value_ff;
         rsp_status_ff <= status_ff;
      end
   end

`ifndef SYNTHESIS
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> ((state_ff == ST_FILL) || ((state_ff == ST_ROT) && phase_ff[2])))
      else $error("Grid written outside the fill or rotation write phases.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("Response raised without a finished request.");

   a_rot_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT) |-> ((i_ff < rad_ff) && (j_ff <= rad_ff)))
      else $error("Rotation group counters out of range.");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_RWAIT) ##1 (state_ff == ST_DONE))
      else $error("Read did not complete through the wait state.");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for square_region_rotator_core
// Drives initialise, rotate, read and unknown-opcode transactions through the request channel
// in random bursts, rewrites the side register between phases, and checks
// each response against a behavioural grid held in the bench.
// ---------------------------------------------------------------------------
module testbench;

   localparam logic [srr_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_OPS   = 27;

   typedef struct packed {
      logic [srr_pkg::OP_W-1:0]  opcode;
      logic [srr_pkg::POS_W-1:0] row;
      logic [srr_pkg::POS_W-1:0] col;
      logic [srr_pkg::RAD_W-1:0] radius;
      logic                      direction;
   } rotator_op_type;

   typedef struct packed {
      logic [srr_pkg::VAL_W-1:0] cell_value;
      logic                      status;
   } rotator_reply_type;

   logic clock;
   logic reset;

   srr_req_if req_chan ();
   srr_rsp_if rsp_chan ();
   srr_csr_if csr_chan ();

   square_region_rotator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   rotator_op_type    ops_to_send [$];
   rotator_reply_type replies_due [$];

   logic [srr_pkg::VAL_W-1:0] grid_model [0:srr_pkg::DEPTH-1];
   int unsigned               side_model;

   int             cycle_count;
   int             mismatch_count;
   logic           req_taken;
   rotator_op_type next_op;
   rotator_op_type seen_op;
   int             burst_left;
   int             gap_left;
   int             rsp_tick;
   int             hold_left;
   logic           long_hold_req;
   logic           long_hold_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned used_side();
      return (side_model > srr_pkg::MAX_SIDE) ? srr_pkg::MAX_SIDE : side_model;
   endfunction

   function automatic void refill_grid();
      int unsigned n;
      int unsigned r;
      int unsigned c;
      n = used_side();
      for (r = 0; r < n; r++)
         for (c = 0; c < n; c++)
            grid_model[r * srr_pkg::MAX_SIDE + c] = srr_pkg::VAL_W'(r * n + c + 1);
   endfunction

   function automatic bit turn_region(input int unsigned x, input int unsigned y,
                                      input int unsigned rad, input logic dir);
      logic [srr_pkg::VAL_W-1:0] snap [0:30][0:30];
      int unsigned n;
      int unsigned w;
      int unsigned base;
      int unsigned p;
      int unsigned q;
      int unsigned sp;
      int unsigned sq;
      n = used_side();
      w = 2 * rad + 1;
      if (x <= rad || y <= rad || x + rad > n || y + rad > n)
         return 1'b0;
      base = (x - rad - 1) * srr_pkg::MAX_SIDE + (y - rad - 1);
      for (p = 0; p < w; p++)
         for (q = 0; q < w; q++)
            snap[p][q] = grid_model[base + p * srr_pkg::MAX_SIDE + q];
      for (p = 0; p < w; p++)
         for (q = 0; q < w; q++) begin
            if (dir == srr_pkg::DIR_CW) begin
               sp = w - 1 - q;
               sq = p;
            end else begin
               sp = q;
               sq = w - 1 - p;
            end
            grid_model[base + p * srr_pkg::MAX_SIDE + q] = snap[sp][sq];
         end
      return 1'b1;
   endfunction

   function automatic rotator_reply_type model_grid_op(input rotator_op_type op);
      rotator_reply_type reply;
      int unsigned       n;
      int unsigned       r;
      int unsigned       c;
      n = used_side();
      r = op.row;
      c = op.col;
      reply.cell_value = '0;
      reply.status     = srr_pkg::STATUS_DONE;
      case (op.opcode)
         srr_pkg::OP_INIT: refill_grid();
         srr_pkg::OP_ROTATE: begin
            if (!turn_region(r, c, op.radius, op.direction))
               reply.status = srr_pkg::STATUS_ERROR;
         end
         srr_pkg::OP_READ: begin
            if (r >= 1 && c >= 1 && r <= n && c <= n)
               reply.cell_value = grid_model[(r - 1) * srr_pkg::MAX_SIDE + (c - 1)];
            else
               reply.status = srr_pkg::STATUS_ERROR;
         end
         default: reply.status = srr_pkg::STATUS_ERROR;
      endcase
      return reply;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic queue_op(input logic [srr_pkg::OP_W-1:0] opcode, input int row,
                           input int col, input int radius, input logic direction);
      rotator_op_type op;
      op.opcode    = opcode;
      op.row       = srr_pkg::POS_W'(row);
      op.col       = srr_pkg::POS_W'(col);
      op.radius    = srr_pkg::RAD_W'(radius);
      op.direction = direction;
      ops_to_send.push_back(op);
   endtask

   task automatic queue_random_ops(input int count);
      int unsigned n;
      int unsigned rmax;
      int unsigned rad;
      int unsigned pick;
      logic        sane;
      n = used_side();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         sane = (n != 0) && ($urandom_range(0, 99) < 85);
         if (pick < 6) begin
            queue_op(srr_pkg::OP_INIT, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), $urandom_range(0, 1));
         end else if (pick < 50 && sane) begin
            rmax = (n - 1) / 2;
            if (rmax > 15)
               rmax = 15;
            if ($urandom_range(0, 9) == 0)
               rad = $urandom_range(0, rmax);
            else
               rad = $urandom_range(0, (rmax < 3) ? rmax : 3);
            queue_op(srr_pkg::OP_ROTATE, $urandom_range(rad + 1, n - rad),
                     $urandom_range(rad + 1, n - rad), rad, $urandom_range(0, 1));
         end else if (pick < 50) begin
            queue_op(srr_pkg::OP_ROTATE, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), $urandom_range(0, 1));
         end else if (pick < 96 && sane) begin
            queue_op(srr_pkg::OP_READ, $urandom_range(1, n), $urandom_range(1, n),
                     $urandom_range(0, 15), $urandom_range(0, 1));
         end else if (pick < 96) begin
            queue_op(srr_pkg::OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), $urandom_range(0, 1));
         end else begin
            queue_op(OP_UNKNOWN, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 15), $urandom_range(0, 1));
         end
      end
   endtask

   task automatic write_side(input int unsigned value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.side  <= srr_pkg::SIDE_W'(value);
      do @(posedge clock); while (!csr_chan.ready);
      side_model = value & 32'h3F;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      while (ops_to_send.size() != 0 || req_chan.valid || replies_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Sender: offers queued operations in bursts separated by random gaps.
   always @(negedge clock) begin
      if (!reset && (!req_chan.valid || req_taken)) begin
         if (req_taken) begin
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (gap_left != 0 || ops_to_send.size() == 0) begin
            if (gap_left != 0)
               gap_left--;
            req_chan.valid <= 1'b0;
         end else begin
            next_op = ops_to_send.pop_front();
            req_chan.opcode    <= next_op.opcode;
            req_chan.row       <= next_op.row;
            req_chan.col       <= next_op.col;
            req_chan.radius    <= next_op.radius;
            req_chan.direction <= next_op.direction;
            req_chan.valid     <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen_op.opcode    = req_chan.opcode;
         seen_op.row       = req_chan.row;
         seen_op.col       = req_chan.col;
         seen_op.radius    = req_chan.radius;
         seen_op.direction = req_chan.direction;
         replies_due.push_back(model_grid_op(seen_op));
      end
   end

   // Receiver: stall level steps through four settings in turn, with one long hold-off.
   always @(negedge clock) begin
      int pct;
      rsp_tick++;
      case ((rsp_tick / 97) % 4)
         0:       pct = 0;
         1:       pct = 30;
         2:       pct = 70;
         default: pct = 95;
      endcase
      if (long_hold_req && !long_hold_taken) begin
         long_hold_taken = 1'b1;
         hold_left       = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= pct);
      end
   end

   always @(posedge clock) begin
      rotator_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("response with nothing outstanding: value %0d status %0d",
                                      rsp_chan.cell_value, rsp_chan.status));
         end else begin
            want = replies_due.pop_front();
            if (rsp_chan.cell_value !== want.cell_value)
               report_mismatch($sformatf("cell value %0d, expected %0d",
                                         rsp_chan.cell_value, want.cell_value));
            if (rsp_chan.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_chan.status, want.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned side_plan [9];
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.opcode    = srr_pkg::OP_INIT;
      req_chan.row       = '0;
      req_chan.col       = '0;
      req_chan.radius    = '0;
      req_chan.direction = srr_pkg::DIR_CW;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.side      = '0;
      req_taken          = 1'b0;
      burst_left         = 1;
      gap_left           = 0;
      rsp_tick           = 0;
      hold_left          = 0;
      long_hold_req      = 1'b0;
      long_hold_taken    = 1'b0;
      cycle_count        = 0;
      mismatch_count     = 0;
      side_model         = srr_pkg::SIDE_RESET;
      for (int i = 0; i < srr_pkg::DEPTH; i++)
         grid_model[i] = '0;
      refill_grid();
      side_plan    = '{1, 0, 63, 40, 5, 17, 2, 24, 32};
      side_plan[7] = $urandom_range(3, 31);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_op(srr_pkg::OP_READ, 1, 1, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 32, 32, 15, srr_pkg::DIR_CCW);
      queue_op(srr_pkg::OP_READ, 0, 5, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 5, 0, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 33, 1, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 63, 63, 0, srr_pkg::DIR_CW);
      queue_op(OP_UNKNOWN, 63, 63, 15, srr_pkg::DIR_CCW);
      queue_op(srr_pkg::OP_ROTATE, 16, 16, 15, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 1, 1, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 31, 1, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_ROTATE, 16, 16, 15, srr_pkg::DIR_CCW);
      queue_op(srr_pkg::OP_READ, 1, 1, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_ROTATE, 1, 1, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_ROTATE, 1, 1, 1, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_ROTATE, 32, 32, 1, srr_pkg::DIR_CCW);
      queue_op(srr_pkg::OP_ROTATE, 15, 16, 15, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_ROTATE, 31, 31, 1, srr_pkg::DIR_CCW);
      queue_op(srr_pkg::OP_READ, 30, 30, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_ROTATE, 0, 0, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_INIT, 0, 0, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 31, 31, 0, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_ROTATE, 17, 17, 15, srr_pkg::DIR_CW);
      queue_op(srr_pkg::OP_READ, 2, 2, 0, srr_pkg::DIR_CW);
      drain();

      long_hold_req = 1'b1;
      queue_random_ops(PHASE_OPS);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         write_side(side_plan[ph]);
         queue_random_ops(PHASE_OPS);
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/srr_pkg.sv
rtl/srr_if.sv
rtl/srr_grid_mem.sv
rtl/square_region_rotator_core.sv
dv/testbench.sv
